// ===== hw/rtl/exp_tanh_sigmoid_unit_macros.svh =====
// Assertion macros used by the checker of the exp/tanh/sigmoid unit.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef EXP_TANH_SIGMOID_UNIT_MACROS_SVH
`define EXP_TANH_SIGMOID_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ets_pkg.sv =====
// Shared constants, types and codes of the exp/tanh/sigmoid unit.
// No dependencies; every RTL module imports this package.
package ets_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int TAYLOR_TERMS = 8;

	localparam int X_W   = 32;   // input argument width
	localparam int Y_W   = 48;   // result width
	localparam int ARG_W = 33;   // argument of the exponential, room for negation
	localparam int RED_W = 22;   // clamped argument, |x| <= 20
	localparam int K_W   = 6;    // power of two count, -28..28
	localparam int CX_W  = 17;   // reduced argument in the cells, |x| <= ln2
	localparam int TERM_W = 18;  // signed series term, |term| <= 1.0
	localparam int MAG_W  = 17;  // term magnitude
	localparam int SUM_W  = 20;  // signed partial sum, below 2.0
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = 29;
	localparam int RR_SHIFT = 37;  // reciprocal of ln2 used to find k
	localparam int RR_W     = 22;
	localparam int NUM_W = 22;   // divider numerator magnitude
	localparam int DEN_W = 23;   // divider denominator
	localparam int Q_W   = 17;   // divider quotient, at most 1.0

	localparam int ONE_FX     = 1 << FRAC_BITS;
	localparam int LN2_FX     = 45426;
	localparam int EXP_LIMIT  = 20 << FRAC_BITS;
	localparam int TANH_LIMIT = 4 << FRAC_BITS;

	typedef enum logic [1:0] {
		FUNC_EXP  = 2'd0,
		FUNC_TANH = 2'd1,
		FUNC_SIG  = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		EXP_IDLE,
		EXP_REDUCE,
		EXP_FOLD,
		EXP_CHAIN
	} exp_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXP_A,
		ST_EXP_B,
		ST_DIV,
		ST_FIN
	} top_state_t;

	// Data handed from one series cell to the next.
	typedef struct packed {
		logic                     valid;
		logic signed [CX_W-1:0]   x;
		logic signed [TERM_W-1:0] term;
		logic signed [SUM_W-1:0]  sum;
	} cell_bus_t;

endpackage

// ===== hw/rtl/ets_taylor_cell.sv =====
// One Taylor series cell: term <= trunc(term * x) / i, sum <= sum + term.
// Two register stages; depends on ets_pkg.
module ets_taylor_cell import ets_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [RECIP_W-1:0] recip,
	input  cell_bus_t          bus_in,
	output cell_bus_t          bus_out
);

	logic [MAG_W-1:0]         term_mag;
	logic [CX_W-1:0]          x_mag;
	logic [MAG_W+CX_W-1:0]    prod;
	logic [MAG_W+RECIP_W-1:0] qprod;
	logic [MAG_W:0]           quot;

	logic                     valid_s1;
	logic                     neg_s1;
	logic [MAG_W-1:0]         pmag_s1;
	logic signed [CX_W-1:0]   x_s1;
	logic signed [SUM_W-1:0]  sum_s1;

	logic                     valid_s2;
	logic signed [CX_W-1:0]   x_s2;
	logic signed [TERM_W-1:0] term_s2;
	logic signed [SUM_W-1:0]  sum_s2;

	always_comb begin
		term_mag = bus_in.term[TERM_W-1] ? MAG_W'(-bus_in.term) : MAG_W'(bus_in.term);
		x_mag    = bus_in.x[CX_W-1] ? CX_W'(-bus_in.x) : CX_W'(bus_in.x);
		prod     = term_mag * x_mag;
		// Division by the cell's index as a multiply by a rounded-up reciprocal.
		qprod    = pmag_s1 * recip;
		quot     = qprod[RECIP_SHIFT +: MAG_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= bus_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= bus_in.term[TERM_W-1] ^ bus_in.x[CX_W-1];
		pmag_s1 <= prod[FRAC_BITS +: MAG_W];
		x_s1    <= bus_in.x;
		sum_s1  <= bus_in.sum;
		x_s2    <= x_s1;
		if (neg_s1) begin
			term_s2 <= -$signed(TERM_W'(quot));
			sum_s2  <= sum_s1 - $signed(SUM_W'(quot));
		end else begin
			term_s2 <= $signed(TERM_W'(quot));
			sum_s2  <= sum_s1 + $signed(SUM_W'(quot));
		end
	end

	assign bus_out = '{valid: valid_s2, x: x_s2, term: term_s2, sum: sum_s2};

endmodule

// ===== hw/rtl/ets_exp_core.sv =====
// Fixed-point exponential: clamp, ln2 range reduction, a chain of series
// cells and a final power-of-two shift. Depends on ets_pkg, ets_taylor_cell.
module ets_exp_core import ets_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ARG_W-1:0] arg,
	output logic                    done,
	output logic [Y_W-1:0]          result
);

	localparam int RM_W = RED_W - 1;
	localparam logic signed [ARG_W-1:0] LIM_HI = ARG_W'(EXP_LIMIT);
	localparam logic signed [ARG_W-1:0] LIM_LO = -ARG_W'(EXP_LIMIT);
	localparam logic signed [RED_W-1:0] LN2_P  = RED_W'(LN2_FX);
	localparam logic [RR_W-1:0] LN2_RECIP =
		RR_W'(((64'd1 << RR_SHIFT) + 64'(LN2_FX) - 64'd1) / 64'(LN2_FX));

	exp_state_t state_q, state_d;
	logic signed [RED_W-1:0] r_q;
	logic signed [K_W-1:0]   k_q;
	logic signed [RED_W-1:0] clamped;
	logic                    launch_q;
	logic [RM_W-1:0]         r_mag;
	logic [RM_W-1:0]         r_dec;
	logic [RM_W+RR_W-1:0]    k_prod;
	logic [K_W-2:0]          k_mag;
	logic signed [K_W-1:0]   k_d;
	logic signed [RED_W-1:0] k_ext;
	logic signed [RED_W-1:0] r_fold;
	logic [Y_W-1:0]          sum_ext;
	logic [K_W-1:0]          k_neg;
	logic [Y_W-1:0]          shifted;
	logic                    done_q;
	logic [Y_W-1:0]          result_q;

	cell_bus_t bus [TAYLOR_TERMS+1];

	always_comb begin
		if (arg > LIM_HI)      clamped = RED_W'(LIM_HI);
		else if (arg < LIM_LO) clamped = RED_W'(LIM_LO);
		else                   clamped = RED_W'(arg);
	end

	// The number of ln2 steps is floor((|x| - 1) / ln2) for x != 0, found by a
	// multiply with a rounded-up reciprocal that is exact over the clamped range.
	always_comb begin
		r_mag  = r_q[RED_W-1] ? RM_W'(-r_q) : RM_W'(r_q);
		r_dec  = (r_mag == '0) ? '0 : r_mag - RM_W'(1);
		k_prod = r_dec * LN2_RECIP;
		k_mag  = k_prod[RR_SHIFT +: K_W-1];
		k_d    = r_q[RED_W-1] ? -$signed({1'b0, k_mag}) : $signed({1'b0, k_mag});
		k_ext  = RED_W'(k_q);
		r_fold = r_q - k_ext * LN2_P;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EXP_IDLE: begin
				if (start) state_d = EXP_REDUCE;
			end
			EXP_REDUCE: begin
				state_d = EXP_FOLD;
			end
			EXP_FOLD: begin
				state_d = EXP_CHAIN;
			end
			EXP_CHAIN: begin
				if (bus[TAYLOR_TERMS].valid) state_d = EXP_IDLE;
			end
			default: state_d = EXP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= EXP_IDLE;
			done_q   <= 1'b0;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			done_q   <= (state_q == EXP_CHAIN) && bus[TAYLOR_TERMS].valid;
			launch_q <= (state_q == EXP_FOLD);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EXP_IDLE && start) r_q <= clamped;
		else if (state_q == EXP_FOLD)     r_q <= r_fold;
		if (state_q == EXP_REDUCE) k_q <= k_d;
		if (bus[TAYLOR_TERMS].valid) result_q <= shifted;
	end

	assign bus[0] = '{
		valid: launch_q,
		x:     CX_W'(r_q),
		term:  TERM_W'(ONE_FX),
		sum:   SUM_W'(ONE_FX)
	};

	for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_cell
		localparam int unsigned DIVISOR = g + 1;
		localparam logic [RECIP_W-1:0] RECIP =
			RECIP_W'(((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);
		ets_taylor_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.recip   (RECIP),
			.bus_in  (bus[g]),
			.bus_out (bus[g+1])
		);
	end

	// Negative sums cannot occur here but are clipped to zero all the same.
	always_comb begin
		sum_ext = bus[TAYLOR_TERMS].sum[SUM_W-1] ? '0
			: Y_W'(bus[TAYLOR_TERMS].sum[SUM_W-2:0]);
		k_neg   = -k_q;
		if (k_q[K_W-1]) shifted = sum_ext >> k_neg[K_W-2:0];
		else            shifted = sum_ext << k_q[K_W-2:0];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hw/rtl/ets_divider.sv =====
// Restoring divider: quotient = (num << FRAC_BITS) / den, one bit a cycle.
// Requires num <= den. Depends on ets_pkg.
module ets_divider import ets_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quot
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0]   bits_q;
	logic [Q_W-1:0]   quot_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, bits_q[Q_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend's top part, num >> 1, is already below den; its last bit
	// and the fraction zeros enter one per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= DEN_W'(num >> 1);
			bits_q <= {num[0], {(Q_W-1){1'b0}}};
		end else if (busy_q) begin
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			bits_q <= bits_q << 1;
			quot_q <= {quot_q[Q_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== hw/rtl/exp_tanh_sigmoid_unit.sv =====
// Top level of the exp/tanh/sigmoid unit.
// Depends on ets_pkg, ets_exp_core (with ets_taylor_cell) and ets_divider.
//
// Usage: the input channel (in_valid/in_stall) carries one beat per item: a
// function code (func: 0 exp, 1 tanh, 2 sigmoid, 3 unused, gives zero) and a
// signed argument x_value with 16 fraction bits. The output channel
// (out_valid/out_stall) returns one beat per item, y_value, signed with 16
// fraction bits. Items are processed one at a time and results stay in order.
//
// Path from the accepted beat to out_valid for exp: the reciprocal multiply
// that finds the ln2 count, the fold of that count out of the argument, the
// eight two-stage series cells, the final shift and two handoffs to the
// output register. Sigmoid adds the 17-step divider and its handoff; tanh runs
// two exponentials and the divider. Saturated tanh and the unused code skip
// the exponential and load their result at once. A new beat is taken only
// after the previous result has left its final state for the output register.
//
// The output register decouples the two channels: a new beat is accepted
// while a finished result still waits on a stalled receiver; the next result
// then waits in its final state until the output register is free.
// Reset clears all control state; the user must present no beat during it, as the block does not stop one being taken.
module exp_tanh_sigmoid_unit import ets_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            func,
	input  logic signed [X_W-1:0] x_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [Y_W-1:0] y_value
);

	localparam logic signed [X_W-1:0] TANH_HI = X_W'(TANH_LIMIT);
	localparam logic signed [X_W-1:0] TANH_LO = -X_W'(TANH_LIMIT);
	localparam logic signed [Y_W-1:0] ONE_Y   = Y_W'(ONE_FX);

	top_state_t state_q, state_d;
	func_t                 func_in;
	func_t                 func_q;
	logic signed [X_W-1:0] x_q;
	logic [NUM_W-1:0]      ep_q;
	logic                  neg_q;
	logic signed [Y_W-1:0] res_q;
	logic                  out_valid_q;
	logic signed [Y_W-1:0] y_q;

	logic                    accept;
	logic signed [ARG_W-1:0] x_in_ext;
	logic signed [ARG_W-1:0] x_q_ext;
	logic                    exp_start;
	logic signed [ARG_W-1:0] exp_arg;
	logic                    exp_done;
	logic [Y_W-1:0]          exp_res;
	logic                    div_start;
	logic [NUM_W-1:0]        div_num;
	logic [DEN_W-1:0]        div_den;
	logic                    div_done;
	logic [Q_W-1:0]          div_quot;
	logic                    div_neg;
	logic                    res_ld;
	logic signed [Y_W-1:0]   res_d;
	logic [NUM_W-1:0]        en;
	logic                    out_free;

	assign func_in  = func_t'(func);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign x_in_ext = ARG_W'(x_value);
	assign x_q_ext  = ARG_W'(x_q);
	assign en       = exp_res[NUM_W-1:0];
	assign out_free = !out_valid_q || !out_stall;

	// Sequencer: launches the exponential(s) and then the divider where the
	// function needs them, and parks the result in res_q.
	always_comb begin
		state_d   = state_q;
		exp_start = 1'b0;
		exp_arg   = x_in_ext;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_neg   = 1'b0;
		res_ld    = 1'b0;
		res_d     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func_in)
						FUNC_EXP: begin
							exp_start = 1'b1;
							state_d   = ST_EXP_A;
						end
						FUNC_TANH: begin
							if (x_value > TANH_HI) begin
								res_ld  = 1'b1;
								res_d   = ONE_Y;
								state_d = ST_FIN;
							end else if (x_value < TANH_LO) begin
								res_ld  = 1'b1;
								res_d   = -ONE_Y;
								state_d = ST_FIN;
							end else begin
								exp_start = 1'b1;
								state_d   = ST_EXP_A;
							end
						end
						FUNC_SIG: begin
							// Both halves of the sigmoid use e^-|x|.
							exp_start = 1'b1;
							exp_arg   = x_value[X_W-1] ? x_in_ext : -x_in_ext;
							state_d   = ST_EXP_A;
						end
						default: begin
							res_ld  = 1'b1;
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_EXP_A: begin
				if (exp_done) begin
					unique case (func_q)
						FUNC_TANH: begin
							exp_start = 1'b1;
							exp_arg   = -x_q_ext;
							state_d   = ST_EXP_B;
						end
						FUNC_SIG: begin
							div_start = 1'b1;
							div_num   = x_q[X_W-1] ? en : NUM_W'(ONE_FX);
							div_den   = DEN_W'(ONE_FX) + DEN_W'(en);
							state_d   = ST_DIV;
						end
						default: begin
							res_ld  = 1'b1;
							res_d   = $signed(exp_res);
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_EXP_B: begin
				if (exp_done) begin
					div_start = 1'b1;
					div_neg   = ep_q < en;
					div_num   = (ep_q < en) ? en - ep_q : ep_q - en;
					div_den   = DEN_W'(ep_q) + DEN_W'(en);
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					res_ld  = 1'b1;
					res_d   = neg_q ? -$signed(Y_W'(div_quot)) : $signed(Y_W'(div_quot));
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (!out_stall)               out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_in;
			x_q    <= x_value;
		end
		if (state_q == ST_EXP_A && exp_done) ep_q <= en;
		if (div_start) neg_q <= div_neg;
		if (res_ld) res_q <= res_d;
		if (state_q == ST_FIN && out_free) y_q <= res_q;
	end

	ets_exp_core u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.arg    (exp_arg),
		.done   (exp_done),
		.result (exp_res)
	);

	ets_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign out_valid = out_valid_q;
	assign y_value   = y_q;

endmodule

// ===== hw/rtl/ets_checker.sv =====
// Port-level checker for the exp/tanh/sigmoid unit, bound to the top level.
// Depends on exp_tanh_sigmoid_unit_macros.svh and ets_pkg.
`include "exp_tanh_sigmoid_unit_macros.svh"

module ets_checker import ets_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic signed [Y_W-1:0] y_value
);

	`ETS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(y_value), "stalled result beat changed")
	`ETS_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second beat taken while an item is in work")
	`ETS_ASSERT_NEXT(a_no_instant, in_valid && !in_stall, !$rose(out_valid), "result appeared one cycle after its beat")

endmodule

bind exp_tanh_sigmoid_unit ets_checker u_checker (.*);

// ===== test/exp_tanh_sigmoid_unit_test.sv =====
// Self-checking testbench of exp_tanh_sigmoid_unit: exponential, tanh and sigmoid.
// Needs ets_pkg and the unit's RTL; the expected values come from a fixed-point
// predictor written in this file.
`timescale 1ns / 100ps

module exp_tanh_sigmoid_unit_test;
	import ets_pkg::*;

	localparam int  HALF_PERIOD = 6;
	localparam int  CYCLE_LIMIT = 1000000;
	// Longest item: tanh runs two exponentials and the divider.
	localparam int  DRAIN_CYCLES = 150;
	localparam longint OUT_MAX = (64'sd1 <<< 47) - 1;
	localparam longint OUT_MIN = -(64'sd1 <<< 47);
	localparam longint FX_ONE = 64'sd1 <<< FRAC_BITS;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            func;
	logic signed [X_W-1:0] x_value;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [Y_W-1:0] y_value;

	// Results still owed by the unit, oldest first.
	logic signed [Y_W-1:0] owed_results[$];
	int  fail_count;
	int  cycle_count;
	// Receiver control: a forced hold-off length and a switch for random stalls.
	int  hold_off_req;
	bit  out_idle_en;
	bit  in_idle_en;

	exp_tanh_sigmoid_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.x_value   (x_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.y_value   (y_value)
	);

	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------
	// Fixed-point predictor. All values carry FRAC_BITS fraction bits
	// and are held in 64 bits; products and quotients truncate toward zero.
	// ---------------------------------------------------------------
	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint fx_product(longint a, longint b);
		longint unsigned p;
		p = (magnitude(a) * magnitude(b)) >> FRAC_BITS;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint fx_quotient(longint num, longint den);
		longint unsigned q;
		q = (magnitude(num) << FRAC_BITS) / longint'(den);
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Range reduction by ln2, a Taylor series, then a scale by 2^k.
	function automatic longint fx_exponential(longint x);
		int k;
		longint term;
		longint sum;
		longint unsigned s;
		k = 0;
		term = FX_ONE;
		sum = FX_ONE;
		if (x > EXP_LIMIT) x = EXP_LIMIT;
		if (x < -EXP_LIMIT) x = -EXP_LIMIT;
		while (x > LN2_FX) begin
			x -= LN2_FX;
			k++;
		end
		while (x < -LN2_FX) begin
			x += LN2_FX;
			k--;
		end
		for (int i = 1; i <= TAYLOR_TERMS; i++) begin
			term = fx_product(term, x) / longint'(i);
			sum += term;
		end
		s = (sum < 0) ? 0 : longint'(sum);
		if (k > 0) s = s << k;
		else if (k < 0) s = s >> (-k);
		if (s > 64'h7fff_ffff_ffff_ffff) s = 64'h7fff_ffff_ffff_ffff;
		return longint'(s);
	endfunction

	function automatic logic signed [Y_W-1:0] activation_of(logic [1:0] f,
			logic signed [X_W-1:0] xv);
		longint x;
		longint y;
		longint ep;
		longint en;
		x = xv;
		case (func_t'(f))
			FUNC_EXP: y = fx_exponential(x);
			FUNC_TANH: begin
				if (x > TANH_LIMIT) y = FX_ONE;
				else if (x < -TANH_LIMIT) y = -FX_ONE;
				else begin
					ep = fx_exponential(x);
					en = fx_exponential(-x);
					y = fx_quotient(ep - en, ep + en);
				end
			end
			FUNC_SIG: begin
				// Use the exponential of a non-positive argument on both sides.
				if (x >= 0) y = fx_quotient(FX_ONE, FX_ONE + fx_exponential(-x));
				else begin
					ep = fx_exponential(x);
					y = fx_quotient(ep, FX_ONE + ep);
				end
			end
			default: y = 0;
		endcase
		if (y > OUT_MAX) y = OUT_MAX;
		if (y < OUT_MIN) y = OUT_MIN;
		return y[Y_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Idle lengths: mostly none or short, a few long.
	// ---------------------------------------------------------------
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offers one beat after an optional gap and waits until the unit takes it.
	// It is called at the edge where the previous beat was accepted, so valid
	// is only lowered when a gap really follows.
	task automatic send_beat(input logic [1:0] f, input logic signed [X_W-1:0] xv);
		int gap;
		gap = in_idle_en ? idle_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		x_value  <= xv;
		do @(posedge clk); while (in_stall);
		owed_results.push_back(activation_of(f, xv));
	endtask

	// A random argument: mostly the interesting range up to and past the
	// clamp, some near the tanh knee or multiples of ln2, some the full 32-bit range.
	function automatic logic signed [X_W-1:0] random_argument();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return $signed($urandom_range(0, 2 * (22 << 16))) - (22 << 16);
		if (r < 75) return $signed($urandom_range(0, 2 * (5 << 16))) - (5 << 16);
		if (r < 85) return $signed($urandom_range(0, 2 * 4096)) - 4096
			+ LN2_FX * ($signed($urandom_range(0, 58)) - 29);
		return $urandom();
	endfunction

	// ---------------------------------------------------------------
	// Output side: random stalls, and a long forced hold-off on request.
	// ---------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req > 0) begin
				stall_left = hold_off_req;
				hold_off_req = 0;
			end else if (stall_left == 0 && out_idle_en) begin
				stall_left = idle_length();
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Every beat taken from the unit is compared with the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result %0d", $time, y_value);
				fail_count++;
			end else begin
				if (y_value !== owed_results[0]) begin
					$display("%0t: y_value expected %0d actual %0d",
						$time, owed_results[0], y_value);
					fail_count++;
				end
				void'(owed_results.pop_front());
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("exp_tanh_sigmoid_unit_test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests.
	// ---------------------------------------------------------------

	// Extremes of the argument, every function, the unused code, the clamp
	// at +/-20, the tanh saturation edge at +/-4 and the ln2 boundaries.
	task automatic test_directed();
		logic signed [X_W-1:0] corners[$];
		corners = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 1, -1,
			LN2_FX, -LN2_FX, LN2_FX + 1, TANH_LIMIT, TANH_LIMIT + 1,
			-TANH_LIMIT, EXP_LIMIT, -EXP_LIMIT - 1};
		in_idle_en = 1'b0;
		out_idle_en = 1'b0;
		foreach (corners[i]) send_beat(FUNC_EXP, corners[i]);
		send_beat(FUNC_TANH, TANH_LIMIT);
		send_beat(FUNC_TANH, -TANH_LIMIT - 1);
		send_beat(FUNC_TANH, 32'sh8000_0000);
		send_beat(FUNC_TANH, 1);
		send_beat(FUNC_SIG, 0);
		send_beat(FUNC_SIG, -1);
		send_beat(FUNC_SIG, 32'sh7fff_ffff);
		send_beat(FUNC_SIG, 32'sh8000_0000);
		send_beat(FUNC_NONE, 32'sh7fff_ffff);
		send_beat(FUNC_NONE, 32'sh8000_0000);
	endtask

	task automatic test_random_function(input func_t f, input int count);
		in_idle_en = 1'b1;
		out_idle_en = 1'b1;
		for (int i = 0; i < count; i++) send_beat(f, random_argument());
	endtask

	// Any code, with stretches where neither side idles.
	task automatic test_random_mixed(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				in_idle_en = $urandom_range(0, 2) != 0;
				out_idle_en = $urandom_range(0, 2) != 0;
			end
			send_beat(2'($urandom_range(0, 3)), random_argument());
		end
	endtask

	// The receiver holds off long enough that the unit fills and stalls
	// its input, while beats keep being offered back to back.
	task automatic test_backpressure();
		in_idle_en = 1'b0;
		out_idle_en = 1'b0;
		hold_off_req = 400;
		for (int i = 0; i < 40; i++) send_beat(2'($urandom_range(0, 2)), random_argument());
		out_idle_en = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_EXP;
		x_value = '0;
		fail_count = 0;
		cycle_count = 0;
		hold_off_req = 0;
		out_idle_en = 1'b0;
		in_idle_en = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_function(FUNC_EXP, 400);
		test_random_function(FUNC_TANH, 350);
		test_random_function(FUNC_SIG, 350);
		test_backpressure();
		test_random_mixed(300);

		in_valid <= 1'b0;
		out_idle_en = 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("exp_tanh_sigmoid_unit_test passed");
		end else begin
			$display("exp_tanh_sigmoid_unit_test failed");
		end
		$finish;
	end

endmodule
